[rtl/lpdw_pkg.sv]
// Package for the loop deadline watchdog: field widths, opcode, status,
// reason and register index codes, and the packed result layout.
// No dependencies.
package lpdw_pkg;

   localparam int unsigned TIME_WIDTH  = 32;
   localparam int unsigned COUNT_WIDTH = 8;
   localparam int unsigned OP_WIDTH    = 2;
   localparam int unsigned CSR_WIDTH   = 32;
   localparam int unsigned CSR_IDX_W   = 2;

   typedef enum logic [1:0] {
      OP_EVALUATE = 2'd0,
      OP_KICK     = 2'd1,
      OP_RESET    = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_WARNING = 2'd1,
      STATUS_EXPIRED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REASON_NOMINAL     = 3'd0,
      REASON_LOOP_MISSED = 3'd1,
      REASON_KICK_WARN   = 3'd2,
      REASON_MAX_MISSED  = 3'd3,
      REASON_TIMEOUT     = 3'd4
   } reason_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOOP_DEADLINE = 2'd0,
      CSR_WARNING       = 2'd1,
      CSR_TIMEOUT       = 2'd2,
      CSR_MAX_MISSED    = 2'd3
   } csr_index_type;

   localparam logic [TIME_WIDTH-1:0]  RST_LOOP_DEADLINE = TIME_WIDTH'(100);
   localparam logic [TIME_WIDTH-1:0]  RST_WARNING       = TIME_WIDTH'(500);
   localparam logic [TIME_WIDTH-1:0]  RST_TIMEOUT       = TIME_WIDTH'(1000);
   localparam logic [COUNT_WIDTH-1:0] RST_MAX_MISSED    = COUNT_WIDTH'(3);

   // Result layout, first field in the highest bits (80 bits, whole bytes).
   typedef struct packed {
      reason_type             reason_code;
      logic [COUNT_WIDTH-1:0] missed_count;
      logic [TIME_WIDTH-1:0]  kick_time_ms;
      logic [TIME_WIDTH-1:0]  elapsed_ms;
      logic                   alive;
      logic                   timing_good;
      logic                   fault;
      status_type             status;
   } result_type;

   localparam int unsigned RSP_WIDTH = $bits(result_type);
   localparam int unsigned REQ_WIDTH = 2 * TIME_WIDTH;

endpackage

[rtl/loop_deadline_watchdog.sv]
// Loop deadline watchdog top level: input register, rule evaluation and
// result register. Depends on lpdw_pkg.
//
// channel | direction | handshake              | payload
// req_    | in        | req_tvalid/req_tready  | tdata {loop_dur_ms, now_ms}, tuser opcode
// rsp_    | out       | rsp_tvalid/rsp_tready  | tdata result_type (80 bits)
// csr_    | in        | csr_we                 | csr_index, csr_wdata
//
// One item per cycle sustained while rsp_tready stays high. An item is held
// in the input register; an evaluate result then loads into the result
// register as the item advances, and rsp_tvalid rises with it.
// Kick, reset and the unused opcode update state (or nothing) and leave no
// result.
// Kicks and resets pass a waiting result; an evaluate holds in the input
// register until the result register is empty or being taken, and req_tready
// drops behind it.
// Synchronous active-high reset clears valid bits, the watchdog state and
// loads the register defaults.
module loop_deadline_watchdog (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [31:0] now_ms, [63:32] loop_dur_ms
   input  logic [lpdw_pkg::REQ_WIDTH-1:0]   req_tdata,
   // [1:0] opcode
   input  logic [lpdw_pkg::OP_WIDTH-1:0]    req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [1:0] status, [2] fault, [3] timing_good, [4] alive,
   // [36:5] elapsed_ms, [68:37] kick_time_ms, [76:69] missed_count,
   // [79:77] reason_code
   output logic [lpdw_pkg::RSP_WIDTH-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  logic [lpdw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lpdw_pkg::CSR_WIDTH-1:0]   csr_wdata
);
   import lpdw_pkg::*;

   // Configuration registers
   logic [TIME_WIDTH-1:0]  loop_deadline_ff;
   logic [TIME_WIDTH-1:0]  warning_ff;
   logic [TIME_WIDTH-1:0]  timeout_ff;
   logic [COUNT_WIDTH-1:0] max_missed_ff;

   // Watchdog state
   logic [TIME_WIDTH-1:0]  kick_time_ff;
   logic [TIME_WIDTH-1:0]  kick_time_in;
   logic [COUNT_WIDTH-1:0] miss_cnt_ff;
   logic [COUNT_WIDTH-1:0] miss_cnt_in;

   // Input register
   logic                   s1_valid_ff;
   opcode_type             s1_op_ff;
   logic [TIME_WIDTH-1:0]  s1_now_ff;
   logic [TIME_WIDTH-1:0]  s1_dur_ff;

   // Result register
   logic                   rsp_valid_ff;
   result_type             rsp_ff;
   result_type             rsp_in;

   logic                   rsp_free;
   logic                   s1_is_eval;
   logic                   s1_advance;
   logic                   req_xfer;

   logic                   overran;
   logic [TIME_WIDTH-1:0]  elapsed;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s1_is_eval = (s1_op_ff == OP_EVALUATE);
   // Items without a result never wait on the output side.
   assign s1_advance = s1_valid_ff && (rsp_free || !s1_is_eval);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_xfer   = req_tvalid && req_tready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         loop_deadline_ff <= RST_LOOP_DEADLINE;
         warning_ff       <= RST_WARNING;
         timeout_ff       <= RST_TIMEOUT;
         max_missed_ff    <= RST_MAX_MISSED;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOOP_DEADLINE: loop_deadline_ff <= csr_wdata[TIME_WIDTH-1:0];
            CSR_WARNING:       warning_ff       <= csr_wdata[TIME_WIDTH-1:0];
            CSR_TIMEOUT:       timeout_ff       <= csr_wdata[TIME_WIDTH-1:0];
            CSR_MAX_MISSED:    max_missed_ff    <= csr_wdata[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Input register: load on transfer, drop when it advances empty-handed.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_op_ff  <= opcode_type'(req_tuser);
         s1_now_ff <= req_tdata[TIME_WIDTH-1:0];
         s1_dur_ff <= req_tdata[2*TIME_WIDTH-1:TIME_WIDTH];
      end
   end

   // Rule evaluation on the held item against the current state
   assign overran = (s1_dur_ff >= loop_deadline_ff);
   assign elapsed = (s1_now_ff >= kick_time_ff) ? (s1_now_ff - kick_time_ff)
                                                : '0;

   always_comb begin
      kick_time_in = kick_time_ff;
      miss_cnt_in  = miss_cnt_ff;
      unique case (s1_op_ff)
         OP_KICK: begin
            kick_time_in = s1_now_ff;
         end
         OP_RESET: begin
            kick_time_in = s1_now_ff;
            miss_cnt_in  = '0;
         end
         OP_EVALUATE: begin
            // saturate at all ones instead of wrapping
            if (overran && (miss_cnt_ff != {COUNT_WIDTH{1'b1}})) begin
               miss_cnt_in = miss_cnt_ff + COUNT_WIDTH'(1);
            end
         end
         default: ;
      endcase
   end

   // Later rules override earlier ones.
   always_comb begin
      rsp_in.status         = STATUS_OK;
      rsp_in.fault          = 1'b0;
      rsp_in.timing_good    = 1'b1;
      rsp_in.alive          = 1'b1;
      rsp_in.reason_code    = REASON_NOMINAL;
      rsp_in.elapsed_ms     = elapsed;
      rsp_in.kick_time_ms   = kick_time_ff;
      rsp_in.missed_count   = miss_cnt_in;
      if (overran) begin
         rsp_in.timing_good    = 1'b0;
         rsp_in.status         = STATUS_WARNING;
         rsp_in.reason_code    = REASON_LOOP_MISSED;
      end
      if ((elapsed >= warning_ff) && (elapsed < timeout_ff)) begin
         rsp_in.status      = STATUS_WARNING;
         rsp_in.reason_code = REASON_KICK_WARN;
      end
      if (miss_cnt_in >= max_missed_ff) begin
         rsp_in.status         = STATUS_EXPIRED;
         rsp_in.fault          = 1'b1;
         rsp_in.timing_good    = 1'b0;
         rsp_in.reason_code    = REASON_MAX_MISSED;
      end
      if (elapsed >= timeout_ff) begin
         rsp_in.status      = STATUS_EXPIRED;
         rsp_in.fault       = 1'b1;
         rsp_in.alive       = 1'b0;
         rsp_in.reason_code = REASON_TIMEOUT;
      end
   end

   // Commit state as the item leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         kick_time_ff <= '0;
         miss_cnt_ff  <= '0;
      end else if (s1_advance) begin
         kick_time_ff <= kick_time_in;
         miss_cnt_ff  <= miss_cnt_in;
      end
   end

   // Result register: hold while stalled, advance on evaluate.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && s1_is_eval) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_is_eval) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // A reset item leaves the counter cleared.
   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && (s1_op_ff == OP_RESET)) |=> (miss_cnt_ff == '0))
      else $error("miss counter not cleared by reset item");

   // Evaluate never lowers the counter.
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_is_eval) |=> (miss_cnt_ff >= $past(miss_cnt_ff)))
      else $error("miss counter decreased on evaluate");

   // Fault goes with expired status.
   a_fault_expired: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.fault == (rsp_ff.status == STATUS_EXPIRED)))
      else $error("fault and status disagree");

   // Loss of alive can only come from the timeout rule.
   a_alive_reason: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.alive) |-> (rsp_ff.reason_code == REASON_TIMEOUT))
      else $error("alive cleared without timeout reason");

endmodule

[dv/tb_top.sv]
// Testbench for loop_deadline_watchdog: kick, reset, evaluate and unused-opcode transfers with
// random idling on both channels; every result is checked against a cycle-free predictor.
// Depends on lpdw_pkg and the watchdog RTL.
module tb_top;
   import lpdw_pkg::*;

   // Opcode the block must ignore: no state change, no result.
   localparam logic [OP_WIDTH-1:0] OP_UNUSED = 2'd3;
   // Drain time for the input and result registers, plus margin for items that leave no result.
   localparam int SETTLE_CYCLES = 6;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_WIDTH-1:0]   req_tdata  = '0;
   logic [OP_WIDTH-1:0]    req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_WIDTH-1:0]   rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_WIDTH-1:0]   csr_wdata  = '0;

   loop_deadline_watchdog u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] now_ms, [63:32] loop_dur_ms
      .req_tuser  (req_tuser),   // [1:0] opcode
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [1:0] status .. [79:77] reason_code, see result_type
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Shadow copy of the registers and the watchdog state.
   logic [TIME_WIDTH-1:0]  cfg_deadline   = RST_LOOP_DEADLINE;
   logic [TIME_WIDTH-1:0]  cfg_warning    = RST_WARNING;
   logic [TIME_WIDTH-1:0]  cfg_timeout    = RST_TIMEOUT;
   logic [COUNT_WIDTH-1:0] cfg_max_missed = RST_MAX_MISSED;
   logic [TIME_WIDTH-1:0]  wd_kick_time   = '0;
   logic [COUNT_WIDTH-1:0] wd_misses      = '0;

   // Running millisecond clock for the random traffic.
   logic [TIME_WIDTH-1:0]  clock_ms = '0;

   result_type verdict_q[$];
   result_type rsp_seen;
   result_type rsp_want;

   bit idle_on = 1'b1;
   int n_fail     = 0;
   int n_eval     = 0;
   int n_kick     = 0;
   int n_unused   = 0;
   int n_checked  = 0;
   int n_writes   = 0;
   int n_settings = 0;

   // ------------------------------------------------------------------
   // Predictor: advance the shadow state by one accepted item and queue
   // the verdict an evaluate must produce.
   // ------------------------------------------------------------------
   task automatic predict_verdict(input logic [OP_WIDTH-1:0] op,
                                  input logic [TIME_WIDTH-1:0] now,
                                  input logic [TIME_WIDTH-1:0] dur);
      result_type            v;
      logic                  overran;
      logic [TIME_WIDTH-1:0] elapsed;
      case (op)
         OP_KICK: begin
            wd_kick_time = now;
            n_kick++;
         end
         OP_RESET: begin
            wd_kick_time = now;
            wd_misses    = '0;
            n_kick++;
         end
         OP_EVALUATE: begin
            overran = (dur >= cfg_deadline);
            // saturate instead of wrapping
            if (overran && wd_misses != '1) wd_misses = wd_misses + COUNT_WIDTH'(1);
            elapsed = (now >= wd_kick_time) ? now - wd_kick_time : '0;

            v.status         = STATUS_OK;
            v.fault          = 1'b0;
            v.timing_good    = 1'b1;
            v.alive          = 1'b1;
            v.reason_code    = REASON_NOMINAL;
            // each later rule overrides the earlier ones
            if (overran) begin
               v.timing_good    = 1'b0;
               v.status         = STATUS_WARNING;
               v.reason_code    = REASON_LOOP_MISSED;
            end
            if (elapsed >= cfg_warning && elapsed < cfg_timeout) begin
               v.status      = STATUS_WARNING;
               v.reason_code = REASON_KICK_WARN;
            end
            if (wd_misses >= cfg_max_missed) begin
               v.status         = STATUS_EXPIRED;
               v.fault          = 1'b1;
               v.timing_good    = 1'b0;
               v.reason_code    = REASON_MAX_MISSED;
            end
            if (elapsed >= cfg_timeout) begin
               v.status      = STATUS_EXPIRED;
               v.fault       = 1'b1;
               v.alive       = 1'b0;
               v.reason_code = REASON_TIMEOUT;
            end
            v.elapsed_ms   = elapsed;
            v.kick_time_ms = wd_kick_time;
            v.missed_count = wd_misses;
            verdict_q.push_back(v);
            n_eval++;
         end
         default: n_unused++;
      endcase
   endtask

   // ------------------------------------------------------------------
   // Result checker: compare each transfer on rsp_ with the oldest verdict.
   // ------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [TIME_WIDTH-1:0] want,
                                       input logic [TIME_WIDTH-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         n_fail++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen = result_type'(rsp_tdata);
         if (verdict_q.size() == 0) begin
            $error("result transfer with no evaluate pending: %h", rsp_tdata);
            n_fail++;
         end else begin
            rsp_want = verdict_q.pop_front();
            check_field("status", TIME_WIDTH'(rsp_want.status),
                        TIME_WIDTH'(rsp_seen.status));
            check_field("fault", TIME_WIDTH'(rsp_want.fault),
                        TIME_WIDTH'(rsp_seen.fault));
            check_field("timing_good", TIME_WIDTH'(rsp_want.timing_good),
                        TIME_WIDTH'(rsp_seen.timing_good));
            check_field("alive", TIME_WIDTH'(rsp_want.alive),
                        TIME_WIDTH'(rsp_seen.alive));
            check_field("elapsed_ms",     rsp_want.elapsed_ms,     rsp_seen.elapsed_ms);
            check_field("kick_time_ms",   rsp_want.kick_time_ms,   rsp_seen.kick_time_ms);
            check_field("missed_count", TIME_WIDTH'(rsp_want.missed_count),
                        TIME_WIDTH'(rsp_seen.missed_count));
            check_field("reason_code", TIME_WIDTH'(rsp_want.reason_code),
                        TIME_WIDTH'(rsp_seen.reason_code));
            n_checked++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: hold rsp_tready high for a while, then drop it for a random
   // burst while idling is enabled.
   // ------------------------------------------------------------------
   initial begin
      forever begin
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (idle_on) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Sender: one transfer on req_. Valid stays high after the transfer so
   // back-to-back items go out without a bubble; a gap drops it first.
   // ------------------------------------------------------------------
   task automatic send_item(input logic [OP_WIDTH-1:0] op,
                            input logic [TIME_WIDTH-1:0] now,
                            input logic [TIME_WIDTH-1:0] dur);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {dur, now};
      do @(posedge clock); while (!req_tready);
      predict_verdict(op, now, dur);
   endtask

   // Drop valid, wait for every verdict to come back, then let the pipeline
   // empty of kicks and resets that leave no result.
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_WIDTH-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_LOOP_DEADLINE: cfg_deadline   = value;
         CSR_WARNING:       cfg_warning    = value;
         CSR_TIMEOUT:       cfg_timeout    = value;
         CSR_MAX_MISSED:    cfg_max_missed = value[COUNT_WIDTH-1:0];
         default: ;
      endcase
      n_writes++;
   endtask

   // Program all four registers once the block is idle.
   task automatic program_regs(input logic [CSR_WIDTH-1:0] deadline,
                               input logic [CSR_WIDTH-1:0] warning,
                               input logic [CSR_WIDTH-1:0] timeout,
                               input logic [CSR_WIDTH-1:0] max_missed);
      wait_quiet();
      write_reg(CSR_LOOP_DEADLINE, deadline);
      write_reg(CSR_WARNING, warning);
      write_reg(CSR_TIMEOUT, timeout);
      write_reg(CSR_MAX_MISSED, max_missed);
      csr_we <= 1'b0;
      n_settings++;
   endtask

   // Random item: mostly evaluates, with kicks, resets and some unused
   // opcodes. Time mostly creeps forward, sometimes jumps or steps back.
   task automatic send_random_item(output logic [OP_WIDTH-1:0] op);
      int                    pick;
      logic [TIME_WIDTH-1:0] dur;
      pick = $urandom_range(0, 99);
      if (pick < 62)      op = OP_EVALUATE;
      else if (pick < 80) op = OP_KICK;
      else if (pick < 92) op = OP_RESET;
      else                op = OP_UNUSED;
      case ($urandom_range(0, 19))
         0:       clock_ms = $urandom;
         1:       clock_ms = clock_ms - $urandom_range(1, 300);
         default: clock_ms = clock_ms + $urandom_range(0, 400);
      endcase
      case ($urandom_range(0, 9))
         0:          dur = $urandom;
         1, 2, 3:    dur = cfg_deadline - 2 + $urandom_range(0, 4); // straddle the deadline
         default:    dur = $urandom_range(0, 150);
      endcase
      send_item(op, clock_ms, dur);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset defaults: each rule in turn, the zero floor on elapsed time,
   // the unused opcode and the time extremes.
   task automatic test_directed_defaults();
      send_item(OP_EVALUATE, 32'd0, 32'd0);              // nominal
      send_item(OP_EVALUATE, 32'd10, 32'd100);           // loop missed at the deadline
      send_item(OP_KICK, 32'd1000, 32'd0);
      send_item(OP_EVALUATE, 32'd1499, 32'd99);          // just short of the warning window
      send_item(OP_EVALUATE, 32'd1500, 32'd0);           // warning
      send_item(OP_EVALUATE, 32'd1999, 32'd100);         // warning overrides loop missed
      send_item(OP_EVALUATE, 32'd2000, 32'd0);           // timeout
      send_item(OP_EVALUATE, 32'd999, 32'd0);            // now before the kick: elapsed zero
      send_item(OP_EVALUATE, 32'd1200, 32'hFFFF_FFFF);   // third miss: max missed
      send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_EVALUATE, 32'd1000, 32'd0);           // state untouched by the unused op
      send_item(OP_RESET, 32'hFFFF_FFFF, 32'd0);
      send_item(OP_EVALUATE, 32'hFFFF_FFFF, 32'd0);
      send_item(OP_EVALUATE, 32'd0, 32'd0);
      send_item(OP_KICK, 32'd0, 32'hFFFF_FFFF);
      send_item(OP_EVALUATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   // Register extremes: all zero, warning at or above timeout, all ones.
   task automatic test_register_extremes();
      // zero thresholds: every evaluate overruns and times out, zero max expires
      program_regs(32'd0, 32'd0, 32'd0, 32'd0);
      send_item(OP_RESET, 32'd50, 32'd0);
      send_item(OP_EVALUATE, 32'd50, 32'd0);
      send_item(OP_EVALUATE, 32'd10, 32'd0);
      // warning window empty when the warning threshold is at or above the timeout
      program_regs(32'd100, 32'd1000, 32'd500, 32'd255);
      send_item(OP_RESET, 32'd0, 32'd0);
      send_item(OP_EVALUATE, 32'd499, 32'd0);
      send_item(OP_EVALUATE, 32'd999, 32'd0);
      // all ones: no overrun below the top, timeout only at full span
      program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_KICK, 32'd0, 32'd0);
      send_item(OP_EVALUATE, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
      send_item(OP_EVALUATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   // Missed-deadline counter runs into its ceiling and holds there.
   task automatic test_counter_saturation();
      program_regs(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd255);
      clock_ms = 32'd0;
      send_item(OP_RESET, clock_ms, 32'd0);
      repeat (265) begin
         clock_ms = clock_ms + $urandom_range(0, 5);
         send_item(OP_EVALUATE, clock_ms, $urandom);
      end
      send_item(OP_RESET, clock_ms, 32'd0);
      send_item(OP_EVALUATE, clock_ms, 32'd0);
   endtask

   // Random traffic under fresh register settings, n counted items.
   task automatic test_random_traffic(input int n);
      int                    sent;
      logic [OP_WIDTH-1:0]   op;
      sent = 0;
      program_regs($urandom_range(20, 200), $urandom_range(0, 1200),
                   $urandom_range(0, 1500), {24'($urandom), 8'($urandom_range(0, 10))});
      while (sent < n) begin
         send_random_item(op);
         if (op != OP_UNUSED) sent++;
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_defaults();
      test_register_extremes();
      test_counter_saturation();
      repeat (4) test_random_traffic(200);
      // last stretch at full rate: no gaps, no stalls
      idle_on = 1'b0;
      test_random_traffic(200);
      wait_quiet();

      $display("Covered %0d evaluates, %0d kicks/resets and %0d unused opcodes",
               n_eval, n_kick, n_unused);
      $display("under %0d register settings (%0d writes); %0d results checked",
               n_settings, n_writes, n_checked);
      if (n_fail == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog on the testbench itself: far beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

[sim.f]
rtl/lpdw_pkg.sv
rtl/loop_deadline_watchdog.sv
dv/tb_top.sv
